>>> sv/keypad_code_lock_with_presence_macros.svh
// Assertion macros for the keypad code lock with presence detection.
`ifndef KEYPAD_CODE_LOCK_WITH_PRESENCE_MACROS_SVH
`define KEYPAD_CODE_LOCK_WITH_PRESENCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define KCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define KCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/kcl_pkg.sv
// Shared types, codes and constants of the keypad code lock.
package kcl_pkg;

    // Default number of keys in one entry.
    localparam int CODE_KEYS_DEF = 4;

    // Keypad code of the '#' key.
    localparam logic [3:0] KEY_HASH = 4'd14;

    // Configuration register reset values.
    localparam logic [15:0] SECRET_CODE_RST       = 16'd34964;
    localparam logic [3:0]  MAX_FAILURES_RST      = 4'd3;
    localparam logic [15:0] LOCKOUT_TICKS_RST     = 16'd180;
    localparam logic [8:0]  PRESENCE_DISTANCE_RST = 9'd60;
    localparam logic [8:0]  JITTER_THRESHOLD_RST  = 9'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SECRET_CODE       = 3'd0;
    localparam logic [2:0] CFG_MAX_FAILURES      = 3'd1;
    localparam logic [2:0] CFG_LOCKOUT_TICKS     = 3'd2;
    localparam logic [2:0] CFG_PRESENCE_DISTANCE = 3'd3;
    localparam logic [2:0] CFG_JITTER_THRESHOLD  = 3'd4;

    // Maximum value of the failure counter.
    localparam logic [3:0] FAILURES_MAX = 4'd15;

    // Kinds of input transaction.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_KEY    = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    // Event reported with every result.
    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_GRANTED       = 3'd1,
        EV_WRONG         = 3'd2,
        EV_LOCKOUT_START = 3'd3,
        EV_RESET         = 3'd4,
        EV_NO_USER_LOCK  = 3'd5,
        EV_USER_DETECTED = 3'd6,
        EV_LOCKOUT_END   = 3'd7
    } t_event;

    // One input transaction.
    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] key_code;
        logic [8:0] distance_cm;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic        door_open;
        logic        user_present;
        logic [2:0]  keys_entered;
        logic [3:0]  failure_count;
        logic        locked_out;
        logic [15:0] lockout_left;
        logic [2:0]  event_res;
    } t_out_item;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] secret_code;
        logic [3:0]  max_failures;
        logic [15:0] lockout_ticks;
        logic [8:0]  presence_distance;
        logic [8:0]  jitter_threshold;
    } t_cfg;

    // Lock state apart from the key entry.
    typedef struct packed {
        logic [3:0]  failures;
        logic [15:0] lockout_counter;
        logic        present;
        logic [8:0]  previous_distance;
        logic        door;
    } t_lock_state;

endpackage

>>> sv/keypad_code_lock_with_presence.sv
// Keypad code lock with presence detection: one transaction per clock cycle while
// the result is not stalled, each producing exactly one result. A transaction is
// captured in an input register, the lock state is updated in a single short
// combinational pass, and the result is held in an output register; the sustained
// rate of one transaction per cycle is set by that single state-update pass. The
// input side stalls only while both registers are full and the result is stalled.
// Configuration registers are written through a plain write port with no wait.
module keypad_code_lock_with_presence
    import kcl_pkg::*;
#(
    parameter int CODE_KEYS = CODE_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "keypad_code_lock_with_presence_macros.svh"

    localparam int ENTRY_W = 4 * CODE_KEYS;
    localparam int CNT_W   = $clog2(CODE_KEYS + 1);

    t_cfg                cfg;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;
    t_lock_state         r_state;
    logic [ENTRY_W-1:0]  r_entry;
    logic [CNT_W-1:0]    r_count;
    t_lock_state         n_state;
    logic [ENTRY_W-1:0]  n_entry;
    logic [CNT_W-1:0]    n_count;
    t_out_item           n_out_item;
    logic                advance;
    logic                fire;

    kcl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    kcl_step #(
        .CODE_KEYS (CODE_KEYS),
        .ENTRY_W   (ENTRY_W),
        .CNT_W     (CNT_W)
    ) u_step (
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_entry  (r_entry),
        .i_count  (r_count),
        .o_state  (n_state),
        .o_entry  (n_entry),
        .o_count  (n_count),
        .o_result (n_out_item)
    );

    // Handshake: the result register frees when empty or taken.
    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Control and lock state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_entry     <= '0;
            r_count     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_state <= n_state;
                r_entry <= n_entry;
                r_count <= n_count;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    // The entry is always empty while a lockout runs.
    `KCL_ASSERT_IMPL(a_entry_empty_in_lockout, i_clk, i_rst_n, r_state.lockout_counter != 16'd0, r_count == '0, "key entry held during lockout")
    // The input side stalls only when both registers are occupied.
    `KCL_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid, "input stalled with free register")
    // A granted transaction leaves the door open.
    `KCL_ASSERT_IMPL(a_granted_opens_door, i_clk, i_rst_n, r_out_valid && r_out_item.event_res == EV_GRANTED, r_out_item.door_open, "access granted but door locked")

endmodule

>>> sv/kcl_cfg.sv
// Configuration register file of the keypad code lock.
module kcl_cfg
    import kcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [2:0]  i_index,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.secret_code       <= SECRET_CODE_RST;
            r_cfg.max_failures      <= MAX_FAILURES_RST;
            r_cfg.lockout_ticks     <= LOCKOUT_TICKS_RST;
            r_cfg.presence_distance <= PRESENCE_DISTANCE_RST;
            r_cfg.jitter_threshold  <= JITTER_THRESHOLD_RST;
        end else if (i_we) begin
            unique case (i_index)
                CFG_SECRET_CODE:       r_cfg.secret_code       <= i_data;
                CFG_MAX_FAILURES:      r_cfg.max_failures      <= i_data[3:0];
                CFG_LOCKOUT_TICKS:     r_cfg.lockout_ticks     <= i_data;
                CFG_PRESENCE_DISTANCE: r_cfg.presence_distance <= i_data[8:0];
                CFG_JITTER_THRESHOLD:  r_cfg.jitter_threshold  <= i_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/kcl_step.sv
// Next-state and result logic for one transaction of the keypad code lock.
module kcl_step
    import kcl_pkg::*;
#(
    parameter int CODE_KEYS = CODE_KEYS_DEF,
    parameter int ENTRY_W   = 4 * CODE_KEYS,
    parameter int CNT_W     = $clog2(CODE_KEYS + 1)
) (
    input  t_in_item             i_item,
    input  t_cfg                 i_cfg,
    input  t_lock_state          i_state,
    input  logic [ENTRY_W-1:0]   i_entry,
    input  logic [CNT_W-1:0]     i_count,
    output t_lock_state          o_state,
    output logic [ENTRY_W-1:0]   o_entry,
    output logic [CNT_W-1:0]     o_count,
    output t_out_item            o_result
);

    logic [ENTRY_W-1:0]    shifted;
    logic [ENTRY_W+15:0]   secret_ext;
    logic [CNT_W-1:0]      count_inc;
    logic                  entry_full;
    logic                  code_match;
    logic [3:0]            fail_inc;
    logic                  in_lockout;
    logic [8:0]            diff;
    logic [CNT_W+2:0]      count_ext;
    t_event                ev;

    // Entry shift, completion, secret match, failure step, lockout, distance.
    always_comb begin
        shifted    = (i_entry << 4) | ENTRY_W'(i_item.key_code);
        secret_ext = {{ENTRY_W{1'b0}}, i_cfg.secret_code};
        count_inc  = i_count + CNT_W'(1);
        entry_full = (count_inc == CNT_W'(CODE_KEYS));
        code_match = (shifted == secret_ext[ENTRY_W-1:0]);
        fail_inc   = (i_state.failures == FAILURES_MAX) ? FAILURES_MAX
                                                         : i_state.failures + 4'd1;
        in_lockout = (i_state.lockout_counter != 16'd0);
        diff       = (i_item.distance_cm > i_state.previous_distance)
                   ? i_item.distance_cm - i_state.previous_distance
                   : i_state.previous_distance - i_item.distance_cm;
    end

    // State update for the transaction.
    always_comb begin
        o_state = i_state;
        o_entry = i_entry;
        o_count = i_count;
        ev      = EV_NONE;
        case (i_item.operation)
            OP_TICK: begin
                if (in_lockout) begin
                    o_state.lockout_counter = i_state.lockout_counter - 16'd1;
                    if (i_state.lockout_counter == 16'd1) begin
                        o_state.failures = 4'd0;
                        o_entry          = '0;
                        o_count          = '0;
                        ev               = EV_LOCKOUT_END;
                    end
                end
            end
            OP_KEY: begin
                if (!in_lockout) begin
                    if (i_item.key_code == KEY_HASH) begin
                        o_state.door     = 1'b0;
                        o_state.failures = 4'd0;
                        o_entry          = '0;
                        o_count          = '0;
                        ev               = EV_RESET;
                    end else if (!entry_full) begin
                        o_entry = shifted;
                        o_count = count_inc;
                    end else begin
                        o_entry = '0;
                        o_count = '0;
                        if (code_match) begin
                            o_state.door     = 1'b1;
                            o_state.failures = 4'd0;
                            ev               = EV_GRANTED;
                        end else if (fail_inc >= i_cfg.max_failures) begin
                            // Lockout of zero length ends at once.
                            o_state.lockout_counter = i_cfg.lockout_ticks;
                            o_state.failures = (i_cfg.lockout_ticks == 16'd0) ? 4'd0
                                                                              : fail_inc;
                            ev = EV_LOCKOUT_START;
                        end else begin
                            o_state.failures = fail_inc;
                            ev               = EV_WRONG;
                        end
                    end
                end
            end
            OP_SAMPLE: begin
                if (!in_lockout && diff > i_cfg.jitter_threshold) begin
                    if (!i_state.present) begin
                        o_state.door = 1'b0;
                        o_entry      = '0;
                        o_count      = '0;
                        ev           = EV_NO_USER_LOCK;
                        if (i_item.distance_cm < i_cfg.presence_distance) begin
                            o_state.present = 1'b1;
                            ev              = EV_USER_DETECTED;
                        end
                    end else if (i_item.distance_cm > i_cfg.presence_distance) begin
                        o_state.present = 1'b0;
                    end
                    o_state.previous_distance = i_item.distance_cm;
                end
            end
            default: ;
        endcase
    end

    // Result fields reflect the state after the transaction.
    always_comb begin
        count_ext                = {3'b000, o_count};
        o_result.door_open       = o_state.door;
        o_result.user_present    = o_state.present;
        o_result.keys_entered    = count_ext[2:0];
        o_result.failure_count   = o_state.failures;
        o_result.locked_out      = (o_state.lockout_counter != 16'd0);
        o_result.lockout_left    = o_state.lockout_counter;
        o_result.event_res       = ev;
    end

endmodule
